/* rtl/ffca_pkg.sv */
`timescale 1ns / 1ps

package ffca_pkg;

	// Pool geometry.
	localparam int MAX_CELLS = 1024;
	localparam int CELL_W    = $clog2(MAX_CELLS);
	localparam int CNT_W     = 11;

	// Reset value of the pool size register.
	localparam logic [CNT_W-1:0] POOL_RESET = CNT_W'(MAX_CELLS);

	// Request kinds carried on req_type.
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	// One entry of the cell store: occupancy, block start flag and block size.
	typedef struct packed {
		logic             busy;
		logic             start;
		logic [CNT_W-1:0] size;
	} cell_entry_t;

	// Access to the cell store from the sequencer.
	typedef struct packed {
		logic              rd_en;
		logic              wr_en;
		logic [CELL_W-1:0] addr;
		cell_entry_t       wdata;
	} ram_req_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_MARK,
		ST_FREE_RD,
		ST_FREE_CHK,
		ST_FREE_CLR
	} ctrl_state_t;

endpackage

/* rtl/first_fit_contiguous_allocator_unit.sv */
// Latency: a rejected request gives its result beat in the cycle after start.
// Allocate walks the pool one cell a cycle, then marks size cells.
// Free reads the block start, checks it, then clears size cells; one request is in flight at a time.
// After reset a clearing pass over all 1024 cells holds busy high; the pool register resets to 1024.
// The result beat lasts one cycle and the receiver cannot stall it.
`timescale 1ns / 1ps

module first_fit_contiguous_allocator_unit import ffca_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pool_we,
	input  logic [CNT_W-1:0]  pool_wdata,
	input  logic              start,
	output logic              busy,
	input  logic              req_type,
	input  logic [CNT_W-1:0]  block_size,
	input  logic [CELL_W-1:0] free_base,
	output logic              done,
	output logic              ok,
	output logic [CELL_W-1:0] base_out,
	output logic [CNT_W-1:0]  used_cells
);

	logic [CNT_W-1:0] pool_q;
	logic [CNT_W-1:0] pool_eff;
	ram_req_t         ram_req;
	cell_entry_t      ram_rdata;

	// Pool size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q <= POOL_RESET;
		end else if (pool_we) begin
			pool_q <= pool_wdata;
		end
	end

	// The pool never reaches beyond the store.
	assign pool_eff = (pool_q > CNT_W'(MAX_CELLS)) ? CNT_W'(MAX_CELLS) : pool_q;

	ffca_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.req_type   (req_type),
		.block_size (block_size),
		.free_base  (free_base),
		.pool       (pool_eff),
		.ram_rdata  (ram_rdata),
		.ram_req    (ram_req),
		.busy       (busy),
		.done       (done),
		.ok         (ok),
		.base_out   (base_out),
		.used_cells (used_cells)
	);

	ffca_cell_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	// A zero size request is refused with a beat in the next cycle.
	a_zero_size_fails: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (block_size == '0) |=> done && !ok)
		else $error("zero size request not refused");

	// A failed result carries a zero base.
	a_fail_base_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !ok |-> base_out == '0)
		else $error("failed result with non-zero base");

	// The used count never exceeds the store.
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_cells <= CNT_W'(MAX_CELLS))
		else $error("used count beyond store size");

endmodule

/* rtl/ffca_cell_ram.sv */
`timescale 1ns / 1ps

module ffca_cell_ram import ffca_pkg::*; (
	input  logic        clk,
	input  ram_req_t    req,
	output cell_entry_t rdata
);

	cell_entry_t mem [MAX_CELLS];
	cell_entry_t rdata_q;

	// Single port store with a registered read.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/ffca_ctrl.sv */
`timescale 1ns / 1ps

module ffca_ctrl import ffca_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              req_type,
	input  logic [CNT_W-1:0]  block_size,
	input  logic [CELL_W-1:0] free_base,
	input  logic [CNT_W-1:0]  pool,
	input  cell_entry_t       ram_rdata,
	output ram_req_t          ram_req,
	output logic              busy,
	output logic              done,
	output logic              ok,
	output logic [CELL_W-1:0] base_out,
	output logic [CNT_W-1:0]  used_cells
);

	ctrl_state_t       state_q, state_d;
	logic [CELL_W-1:0] addr_q;
	logic [CNT_W-1:0]  issue_q;
	logic              vld_s1;
	logic [CELL_W-1:0] idx_s1;
	logic [CNT_W-1:0]  run_len_q;
	logic [CELL_W-1:0] run_start_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  size_q;
	logic [CELL_W-1:0] base_q;
	logic              done_q;
	logic              ok_q;
	logic [CELL_W-1:0] base_out_q;
	logic [CNT_W-1:0]  used_q;

	logic              req_bad;
	logic              issue_go;
	logic              scan_free;
	logic              scan_hit;
	logic              scan_end;
	logic [CNT_W-1:0]  run_len_inc;
	logic [CELL_W-1:0] run_base;
	logic              free_match;
	logic              last_beat;

	// A request that fails without touching the store.
	assign req_bad = (block_size == '0) || (block_size > pool) ||
		((req_type == REQ_FREE) &&
		 (({1'b0, {1'b0, free_base}} + {1'b0, block_size}) > (CNT_W+1)'(MAX_CELLS)));

	// First-fit walk: track the current run of free cells.
	assign issue_go    = issue_q < pool;
	assign scan_free   = vld_s1 && !ram_rdata.busy;
	assign run_len_inc = run_len_q + CNT_W'(1);
	assign run_base    = (run_len_q == '0) ? idx_s1 : run_start_q;
	assign scan_hit    = scan_free && (run_len_inc == size_q);
	assign scan_end    = !vld_s1 && !issue_go;

	assign free_match = ram_rdata.start && (ram_rdata.size == size_q);
	assign last_beat  = cnt_q == CNT_W'(1);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and store access.
	always_comb begin
		state_d       = state_q;
		ram_req       = '0;
		ram_req.addr  = addr_q;
		case (state_q)
			ST_CLEAR: begin
				ram_req.wr_en = 1'b1;
				if (addr_q == CELL_W'(MAX_CELLS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start && !req_bad) begin
					state_d = (req_type == REQ_FREE) ? ST_FREE_RD : ST_SCAN;
				end
			end
			ST_SCAN: begin
				ram_req.rd_en = issue_go;
				ram_req.addr  = issue_q[CELL_W-1:0];
				if (scan_hit) begin
					state_d = ST_MARK;
				end else if (scan_end) begin
					state_d = ST_IDLE;
				end
			end
			ST_MARK: begin
				ram_req.wr_en       = 1'b1;
				ram_req.wdata.busy  = 1'b1;
				ram_req.wdata.start = addr_q == base_q;
				ram_req.wdata.size  = size_q;
				if (last_beat) begin
					state_d = ST_IDLE;
				end
			end
			ST_FREE_RD: begin
				ram_req.rd_en = 1'b1;
				ram_req.addr  = base_q;
				state_d       = ST_FREE_CHK;
			end
			ST_FREE_CHK: begin
				state_d = free_match ? ST_FREE_CLR : ST_IDLE;
			end
			ST_FREE_CLR: begin
				ram_req.wr_en = 1'b1;
				if (last_beat) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Counters, read pipeline and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q    <= '0;
			issue_q   <= '0;
			vld_s1    <= 1'b0;
			run_len_q <= '0;
			cnt_q     <= '0;
			done_q    <= 1'b0;
			used_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					addr_q <= addr_q + CELL_W'(1);
				end
				ST_IDLE: begin
					if (start) begin
						issue_q   <= '0;
						vld_s1    <= 1'b0;
						run_len_q <= '0;
						done_q    <= req_bad;
					end
				end
				ST_SCAN: begin
					vld_s1 <= issue_go;
					if (issue_go) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					if (vld_s1) begin
						run_len_q <= scan_free ? run_len_inc : '0;
					end
					if (scan_hit) begin
						addr_q <= run_base;
						cnt_q  <= size_q;
					end
					if (scan_end) begin
						done_q <= 1'b1;
					end
				end
				ST_MARK: begin
					addr_q <= addr_q + CELL_W'(1);
					cnt_q  <= cnt_q - CNT_W'(1);
					if (last_beat) begin
						done_q <= 1'b1;
						used_q <= used_q + size_q;
					end
				end
				ST_FREE_CHK: begin
					if (free_match) begin
						addr_q <= base_q;
						cnt_q  <= size_q;
					end else begin
						done_q <= 1'b1;
					end
				end
				ST_FREE_CLR: begin
					addr_q <= addr_q + CELL_W'(1);
					cnt_q  <= cnt_q - CNT_W'(1);
					if (last_beat) begin
						done_q <= 1'b1;
						used_q <= used_q - size_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Request fields and result payload.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					size_q     <= block_size;
					base_q     <= free_base;
					ok_q       <= 1'b0;
					base_out_q <= '0;
				end
			end
			ST_SCAN: begin
				idx_s1 <= issue_q[CELL_W-1:0];
				if (scan_free && (run_len_q == '0)) begin
					run_start_q <= idx_s1;
				end
				if (scan_hit) begin
					base_q <= run_base;
				end
			end
			ST_MARK: begin
				if (last_beat) begin
					ok_q       <= 1'b1;
					base_out_q <= base_q;
				end
			end
			ST_FREE_CLR: begin
				if (last_beat) begin
					ok_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy       = state_q != ST_IDLE;
	assign done       = done_q;
	assign ok         = ok_q;
	assign base_out   = base_out_q;
	assign used_cells = used_q;

endmodule

/* bench/ffca_checker.sv */
`timescale 1ns / 1ps

module ffca_checker import ffca_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pool_we,
	input  logic [CNT_W-1:0]  pool_wdata,
	input  logic              start,
	input  logic              busy,
	input  logic              req_type,
	input  logic [CNT_W-1:0]  block_size,
	input  logic [CELL_W-1:0] free_base,
	input  logic              done,
	input  logic              ok,
	input  logic [CELL_W-1:0] base_out,
	input  logic [CNT_W-1:0]  used_cells,
	output int                fault_count,
	output int                open_count
);

	// One result beat as the block should present it.
	typedef struct packed {
		logic              ok;
		logic [CELL_W-1:0] base;
		logic [CNT_W-1:0]  used;
	} grant_t;

	// Shadow copy of the allocator state and its pool register.
	logic             cell_taken [MAX_CELLS];
	logic             head_mark  [MAX_CELLS];
	logic [CNT_W-1:0] head_size  [MAX_CELLS];
	logic [CNT_W-1:0] used_sum;
	logic [CNT_W-1:0] pool_reg;
	grant_t           grant_q [$];
	int               faults;

	// Applies one request to the shadow state and returns the expected result beat.
	function automatic grant_t serve_request(input logic kind, input int size, input int at);
		grant_t g;
		int     lim;
		int     b;
		int     j;
		int     hit;
		bit     fits;
		g   = '0;
		lim = (pool_reg < MAX_CELLS) ? int'(pool_reg) : MAX_CELLS;
		if (kind == REQ_ALLOC) begin
			if (size != 0 && size <= lim) begin
				// First fit: restart the search just past any occupied cell.
				b   = 0;
				hit = -1;
				while (hit < 0 && b + size <= lim) begin
					fits = 1'b1;
					j    = b;
					while (fits && j < b + size) begin
						if (cell_taken[j])
							fits = 1'b0;
						else
							j++;
					end
					if (fits)
						hit = b;
					else
						b = j + 1;
				end
				if (hit >= 0) begin
					for (j = hit; j < hit + size; j++)
						cell_taken[j] = 1'b1;
					head_mark[hit] = 1'b1;
					head_size[hit] = CNT_W'(size);
					used_sum       = used_sum + CNT_W'(size);
					g.ok           = 1'b1;
					g.base         = CELL_W'(hit);
				end
			end
		end else if (size != 0 && size <= lim && head_mark[at] &&
				int'(head_size[at]) == size && at + size <= MAX_CELLS) begin
			// A free must name an existing block start with its exact size.
			for (j = at; j < at + size; j++)
				cell_taken[j] = 1'b0;
			head_mark[at] = 1'b0;
			head_size[at] = '0;
			used_sum      = used_sum - CNT_W'(size);
			g.ok          = 1'b1;
		end
		g.used = used_sum;
		return g;
	endfunction

	// Compare result beats first, then predict for a request accepted at the same edge.
	always @(posedge clk or negedge arst_n) begin : watch
		grant_t got;
		grant_t want;
		int     i;
		if (!arst_n) begin
			for (i = 0; i < MAX_CELLS; i++) begin
				cell_taken[i] = 1'b0;
				head_mark[i]  = 1'b0;
				head_size[i]  = '0;
			end
			used_sum = '0;
			pool_reg = POOL_RESET;
			grant_q.delete();
			faults      = 0;
			fault_count <= 0;
			open_count  <= 0;
		end else begin
			if (pool_we)
				pool_reg = pool_wdata;
			if (done) begin
				got.ok   = ok;
				got.base = base_out;
				got.used = used_cells;
				if (grant_q.size() == 0) begin
					$display("%0t: result beat with nothing expected: ok=%0d base=%0d used=%0d",
						$time, got.ok, got.base, got.used);
					faults++;
				end else begin
					want = grant_q.pop_front();
					if (got !== want) begin
						$display("%0t: expected ok=%0d base=%0d used=%0d, got ok=%0d base=%0d used=%0d",
							$time, want.ok, want.base, want.used, got.ok, got.base, got.used);
						faults++;
					end
				end
			end
			if (start && !busy)
				grant_q.push_back(serve_request(req_type, int'(block_size), int'(free_base)));
			fault_count <= faults;
			open_count  <= grant_q.size();
		end
	end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb import ffca_pkg::*;;

	localparam int STALL_LIMIT = 12000;

	typedef struct packed {
		logic             kind;
		logic [CNT_W-1:0] size;
	} in_flight_t;

	typedef struct packed {
		logic [CELL_W-1:0] base;
		logic [CNT_W-1:0]  size;
	} live_block_t;

	logic              clk;
	logic              arst_n;
	logic              pool_we;
	logic [CNT_W-1:0]  pool_wdata;
	logic              start;
	logic              busy;
	logic              req_type;
	logic [CNT_W-1:0]  block_size;
	logic [CELL_W-1:0] free_base;
	logic              done;
	logic              ok;
	logic [CELL_W-1:0] base_out;
	logic [CNT_W-1:0]  used_cells;
	int                fault_count;
	int                open_count;
	int                idle_run;
	bit                burst;
	in_flight_t        req_q  [$];
	live_block_t       live_q [$];

	first_fit_contiguous_allocator_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.pool_we    (pool_we),
		.pool_wdata (pool_wdata),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.block_size (block_size),
		.free_base  (free_base),
		.done       (done),
		.ok         (ok),
		.base_out   (base_out),
		.used_cells (used_cells)
	);

	ffca_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.pool_we     (pool_we),
		.pool_wdata  (pool_wdata),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.block_size  (block_size),
		.free_base   (free_base),
		.done        (done),
		.ok          (ok),
		.base_out    (base_out),
		.used_cells  (used_cells),
		.fault_count (fault_count),
		.open_count  (open_count)
	);

	// 100 MHz clock.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Keep a list of granted blocks so that most frees name a real one.
	always @(posedge clk) begin : track
		in_flight_t head;
		if (done && req_q.size() != 0) begin
			head = req_q.pop_front();
			if (head.kind == REQ_ALLOC && ok)
				live_q.push_back('{base: base_out, size: head.size});
		end
		if (start && !busy)
			req_q.push_back('{kind: req_type, size: block_size});
	end

	// Watchdog on cycles in which no beat moves in either direction.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_run <= 0;
		end else if (idle_run == STALL_LIMIT) begin
			$display("[first_fit_contiguous_allocator_unit] ERROR");
			$finish;
		end else begin
			idle_run <= idle_run + 1;
		end
	end

	// Present one request at a falling edge and hold it until the block takes it.
	task automatic send_request(input logic kind, input logic [CNT_W-1:0] size,
			input logic [CELL_W-1:0] at);
		int gap;
		int i;
		if (kind == REQ_FREE) begin
			for (i = live_q.size() - 1; i >= 0; i--) begin
				if (live_q[i].base == at && live_q[i].size == size)
					live_q.delete(i);
			end
		end
		req_type   <= kind;
		block_size <= size;
		free_base  <= at;
		start      <= 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
		gap = burst ? 0 : $urandom_range(0, 18);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Drop start and wait until every result beat has come back.
	task automatic settle();
		start <= 1'b0;
		while (open_count != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	// Mostly allocations and exact frees of live blocks, with some broken and noisy requests.
	task automatic random_request(input int lim);
		int          roll;
		int          idx;
		int          top_sz;
		live_block_t blk;
		roll   = $urandom_range(0, 99);
		top_sz = (lim < 1) ? 1 : lim;
		if (roll >= 50 && roll < 92 && live_q.size() != 0) begin
			idx = $urandom_range(0, live_q.size() - 1);
			blk = live_q[idx];
			if (roll < 85)
				send_request(REQ_FREE, blk.size, blk.base);
			else if ($urandom_range(0, 1) == 1)
				send_request(REQ_FREE, blk.size + 1'b1, blk.base);
			else
				send_request(REQ_FREE, blk.size - 1'b1, blk.base);
		end else if (roll >= 92) begin
			case ($urandom_range(0, 2))
				0: begin
					send_request(REQ_FREE, CNT_W'($urandom), CELL_W'($urandom));
				end
				1: begin
					send_request(REQ_ALLOC, CNT_W'($urandom), CELL_W'($urandom));
				end
				default: begin
					send_request(REQ_ALLOC, '0, CELL_W'($urandom));
				end
			endcase
		end else if ($urandom_range(0, 9) == 0) begin
			send_request(REQ_ALLOC, CNT_W'($urandom_range(1, top_sz)), CELL_W'($urandom));
		end else begin
			send_request(REQ_ALLOC, CNT_W'($urandom_range(1, top_sz < 12 ? top_sz : 12)),
				CELL_W'($urandom));
		end
	endtask

	// Set a new pool size while the block is idle, then run random requests against it.
	task automatic run_phase(input logic [CNT_W-1:0] pool_val, input int count);
		int lim;
		int n;
		settle();
		pool_we    <= 1'b1;
		pool_wdata <= pool_val;
		@(negedge clk);
		pool_we <= 1'b0;
		lim = (pool_val < MAX_CELLS) ? int'(pool_val) : MAX_CELLS;
		for (n = 0; n < count; n++) begin
			if (n % 24 == 0)
				burst = ($urandom_range(0, 3) == 0);
			random_request(lim);
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		pool_we    = 1'b0;
		pool_wdata = POOL_RESET;
		start      = 1'b0;
		req_type   = REQ_ALLOC;
		block_size = '0;
		free_base  = '0;
		burst      = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed requests on the full pool left by reset.
		send_request(REQ_ALLOC, 11'd0, 10'd0);
		send_request(REQ_ALLOC, 11'd2047, 10'd1023);
		send_request(REQ_ALLOC, 11'd1025, 10'd0);
		send_request(REQ_ALLOC, 11'd1024, 10'd0);
		send_request(REQ_ALLOC, 11'd1, 10'd0);
		send_request(REQ_FREE, 11'd0, 10'd0);
		send_request(REQ_FREE, 11'd1023, 10'd0);
		send_request(REQ_FREE, 11'd1024, 10'd0);
		send_request(REQ_ALLOC, 11'd1, 10'd1023);
		send_request(REQ_ALLOC, 11'd3, 10'd0);
		send_request(REQ_ALLOC, 11'd2, 10'd0);
		send_request(REQ_FREE, 11'd3, 10'd1);
		send_request(REQ_ALLOC, 11'd2, 10'd0);
		send_request(REQ_ALLOC, 11'd2, 10'd0);
		send_request(REQ_FREE, 11'd1, 10'd1023);
		send_request(REQ_FREE, 11'd1, 10'd5);
		send_request(REQ_FREE, 11'd2047, 10'd4);
		send_request(REQ_ALLOC, 11'd1, 10'd0);
		send_request(REQ_ALLOC, 11'd1017, 10'd0);
		send_request(REQ_ALLOC, 11'd1016, 10'd0);
		send_request(REQ_FREE, 11'd1016, 10'd8);

		// Random phases over small, empty, oversized and shrunk pools.
		run_phase(11'd16, 120);
		run_phase(11'd1, 25);
		run_phase(11'd0, 15);
		run_phase(11'd2047, 60);
		run_phase(11'd64, 150);
		run_phase(11'd8, 60);
		run_phase(11'd1024, 50);
		run_phase(11'd200, 80);

		settle();
		repeat (20) @(negedge clk);
		if (fault_count == 0 && open_count == 0)
			$display("[first_fit_contiguous_allocator_unit] OK");
		else
			$display("[first_fit_contiguous_allocator_unit] ERROR");
		$finish;
	end

endmodule

/* filelist.f */
rtl/ffca_pkg.sv
rtl/ffca_cell_ram.sv
rtl/ffca_ctrl.sv
rtl/first_fit_contiguous_allocator_unit.sv
bench/ffca_checker.sv
bench/tb.sv
